[sv/source_text_tokenizer_defines.svh]
// Assertion macros shared by the tokenizer modules.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_DEFINES_SVH

// The condition must never hold outside reset.
`define STT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// When pre holds, post must hold at the next clock edge.
`define STT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[sv/stt_pkg.sv]
// Package for the source text tokenizer: payload types, scan modes,
// token kinds, character constants and character class functions. No dependencies.
`timescale 1ns / 1ps

package stt_pkg;

  localparam int POS_BITS = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef logic [POS_BITS-1:0] pos_t;

  localparam pos_t POS_ONE = pos_t'(1);

  typedef enum logic [3:0] {
    SCAN_IDLE,
    SCAN_IDENT,
    SCAN_NUMBER,
    SCAN_STRING,
    SCAN_LINECMT,
    SCAN_BLOCK,
    SCAN_BLOCKBANG,
    SCAN_SLASH,
    SCAN_DOT,
    SCAN_AMP,
    SCAN_EQ,
    SCAN_LT,
    SCAN_MINUS
  } scan_mode_t;

  localparam logic [4:0] K_IDENT     = 5'd0;
  localparam logic [4:0] K_INT       = 5'd1;
  localparam logic [4:0] K_FLOAT     = 5'd2;
  localparam logic [4:0] K_STRING    = 5'd3;
  localparam logic [4:0] K_UNKNOWN   = 5'd4;
  localparam logic [4:0] K_AND_EQ    = 5'd5;
  localparam logic [4:0] K_FAT_ARROW = 5'd6;
  localparam logic [4:0] K_ASSIGN    = 5'd7;
  localparam logic [4:0] K_MOVE      = 5'd8;
  localparam logic [4:0] K_LT        = 5'd9;
  localparam logic [4:0] K_ARROW     = 5'd10;
  localparam logic [4:0] K_MINUS     = 5'd11;
  localparam logic [4:0] K_PLUS      = 5'd12;
  localparam logic [4:0] K_MULT      = 5'd13;
  localparam logic [4:0] K_DIV       = 5'd14;
  localparam logic [4:0] K_MOD       = 5'd15;
  localparam logic [4:0] K_LPAREN    = 5'd16;
  localparam logic [4:0] K_RPAREN    = 5'd17;
  localparam logic [4:0] K_LBRACE    = 5'd18;
  localparam logic [4:0] K_RBRACE    = 5'd19;
  localparam logic [4:0] K_SEMI      = 5'd20;
  localparam logic [4:0] K_COMMA     = 5'd21;
  localparam logic [4:0] K_COLON     = 5'd22;
  localparam logic [4:0] K_EOF       = 5'd23;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  typedef struct packed {
    logic       req_type;
    logic [7:0] char_byte;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] offset;
    logic [15:0] length;
    logic [15:0] line;
    logic [15:0] column;
  } token_t;

  typedef struct packed {
    logic   two;
    token_t t0;
    token_t t1;
  } run_t;

  function automatic pos_t sat_inc(pos_t v);
    return (v == '1) ? v : v + POS_ONE;
  endfunction

  function automatic logic [15:0] out16(pos_t v);
    logic [POS_BITS+15:0] w;
    w = {16'b0, v};
    return w[15:0];
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
  endfunction

  function automatic logic is_word(logic [7:0] b);
    return is_alpha(b) || is_digit(b) || (b == CH_UNDER);
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return (b == " ") || ((b >= 8'd9) && (b <= 8'd13));
  endfunction

  function automatic logic [4:0] single_kind(logic [7:0] b);
    logic [4:0] k;
    case (b)
      "+":     k = K_PLUS;
      "*":     k = K_MULT;
      "%":     k = K_MOD;
      "(":     k = K_LPAREN;
      ")":     k = K_RPAREN;
      "{":     k = K_LBRACE;
      "}":     k = K_RBRACE;
      ";":     k = K_SEMI;
      ",":     k = K_COMMA;
      ":":     k = K_COLON;
      default: k = K_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

[sv/stt_front.sv]
// Scanner front end: accepts source bytes, tracks position and scan mode,
// and packs the tokens that each byte causes into one queue entry. Uses stt_pkg.
`timescale 1ns / 1ps

module stt_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_valid,
  input  stt_pkg::in_item_t byte_item,
  input  logic             queue_full,
  output logic             byte_stall,
  output logic             push,
  output stt_pkg::run_t    run
);
  import stt_pkg::*;

  scan_mode_t mode, mode_next;
  logic       has_dot, has_dot_next;
  pos_t       pos, pos_next;
  pos_t       line, line_next;
  pos_t       col, col_next;
  pos_t       ts_off, ts_off_next;
  pos_t       ts_line, ts_line_next;
  pos_t       ts_col, ts_col_next;

  logic       accept;
  logic [7:0] b;
  pos_t       pos_c, line_c, col_c;
  logic       pend, pend_after, disp, single;
  logic [4:0] pend_kind, one_kind;
  pos_t       pend_len;
  token_t     pend_tok, second_tok;

  assign byte_stall = queue_full;
  assign accept = byte_valid && !byte_stall;
  assign b = byte_item.char_byte;

  always_comb begin
    pos_c = sat_inc(pos);
    if (b == CH_NL) begin
      line_c = sat_inc(line);
      col_c = POS_ONE;
    end else begin
      line_c = line;
      col_c = sat_inc(col);
    end
  end

  always_comb begin
    mode_next = mode;
    has_dot_next = has_dot;
    pos_next = pos_c;
    line_next = line_c;
    col_next = col_c;
    ts_off_next = ts_off;
    ts_line_next = ts_line;
    ts_col_next = ts_col;
    pend = 1'b0;
    pend_kind = K_IDENT;
    pend_after = 1'b0;
    disp = 1'b0;
    single = 1'b0;
    one_kind = K_UNKNOWN;
    if (byte_item.req_type) begin
      pend = 1'b1;
      case (mode)
        SCAN_IDENT:  pend_kind = K_IDENT;
        SCAN_NUMBER: pend_kind = has_dot ? K_FLOAT : K_INT;
        SCAN_STRING: pend_kind = K_STRING;
        SCAN_SLASH:  pend_kind = K_DIV;
        SCAN_DOT:    pend_kind = K_UNKNOWN;
        SCAN_AMP:    pend_kind = K_UNKNOWN;
        SCAN_EQ:     pend_kind = K_ASSIGN;
        SCAN_LT:     pend_kind = K_LT;
        SCAN_MINUS:  pend_kind = K_MINUS;
        default:     pend = 1'b0;
      endcase
      mode_next = SCAN_IDLE;
      has_dot_next = 1'b0;
      pos_next = '0;
      line_next = POS_ONE;
      col_next = POS_ONE;
      ts_off_next = '0;
      ts_line_next = POS_ONE;
      ts_col_next = POS_ONE;
    end else begin
      case (mode)
        SCAN_IDENT: begin
          if (!is_word(b)) begin
            pend = 1'b1;
            pend_kind = K_IDENT;
            disp = 1'b1;
          end
        end
        SCAN_NUMBER: begin
          if (is_digit(b)) begin
            has_dot_next = has_dot;
          end else if ((b == CH_DOT) && !has_dot) begin
            has_dot_next = 1'b1;
          end else begin
            pend = 1'b1;
            pend_kind = has_dot ? K_FLOAT : K_INT;
            disp = 1'b1;
          end
        end
        SCAN_STRING: begin
          if (b == CH_QUOTE) begin
            pend = 1'b1;
            pend_kind = K_STRING;
            mode_next = SCAN_IDLE;
          end
        end
        SCAN_LINECMT: begin
          if (b == CH_NL) begin
            disp = 1'b1;
          end
        end
        SCAN_BLOCK: begin
          if (b == CH_BANG) begin
            mode_next = SCAN_BLOCKBANG;
          end
        end
        SCAN_BLOCKBANG: begin
          if (b == CH_SLASH) begin
            mode_next = SCAN_IDLE;
          end else if (b != CH_BANG) begin
            mode_next = SCAN_BLOCK;
          end
        end
        SCAN_SLASH: begin
          if (b == CH_BANG) begin
            mode_next = SCAN_BLOCK;
          end else if (b == CH_STAR) begin
            mode_next = SCAN_LINECMT;
          end else begin
            pend = 1'b1;
            pend_kind = K_DIV;
            disp = 1'b1;
          end
        end
        SCAN_DOT: begin
          if (is_digit(b)) begin
            mode_next = SCAN_NUMBER;
            has_dot_next = 1'b1;
          end else begin
            pend = 1'b1;
            pend_kind = K_UNKNOWN;
            disp = 1'b1;
          end
        end
        SCAN_AMP: begin
          pend = 1'b1;
          if (b == CH_EQ) begin
            pend_kind = K_AND_EQ;
            pend_after = 1'b1;
            mode_next = SCAN_IDLE;
          end else begin
            pend_kind = K_UNKNOWN;
            disp = 1'b1;
          end
        end
        SCAN_EQ: begin
          pend = 1'b1;
          if (b == CH_GT) begin
            pend_kind = K_FAT_ARROW;
            pend_after = 1'b1;
            mode_next = SCAN_IDLE;
          end else begin
            pend_kind = K_ASSIGN;
            disp = 1'b1;
          end
        end
        SCAN_LT: begin
          pend = 1'b1;
          if (b == CH_MINUS) begin
            pend_kind = K_MOVE;
            pend_after = 1'b1;
            mode_next = SCAN_IDLE;
          end else begin
            pend_kind = K_LT;
            disp = 1'b1;
          end
        end
        SCAN_MINUS: begin
          pend = 1'b1;
          if (b == CH_GT) begin
            pend_kind = K_ARROW;
            pend_after = 1'b1;
            mode_next = SCAN_IDLE;
          end else begin
            pend_kind = K_MINUS;
            disp = 1'b1;
          end
        end
        default: begin
          disp = 1'b1;
        end
      endcase
      if (disp) begin
        mode_next = SCAN_IDLE;
        if (!is_space(b)) begin
          ts_off_next = pos;
          ts_line_next = line;
          ts_col_next = col;
          if (is_alpha(b) || (b == CH_UNDER)) begin
            mode_next = SCAN_IDENT;
          end else if (is_digit(b)) begin
            mode_next = SCAN_NUMBER;
            has_dot_next = 1'b0;
          end else begin
            case (b)
              CH_DOT:   mode_next = SCAN_DOT;
              CH_SLASH: mode_next = SCAN_SLASH;
              CH_AMP:   mode_next = SCAN_AMP;
              CH_EQ:    mode_next = SCAN_EQ;
              CH_LT:    mode_next = SCAN_LT;
              CH_MINUS: mode_next = SCAN_MINUS;
              CH_QUOTE: begin
                mode_next = SCAN_STRING;
                ts_off_next = pos_c;
                ts_line_next = line_c;
                ts_col_next = col_c;
              end
              default: begin
                single = 1'b1;
                one_kind = single_kind(b);
              end
            endcase
          end
        end
      end
    end
  end

  always_comb begin
    pend_len = (pend_after ? pos_c : pos) - ts_off;
    pend_tok.kind = pend_kind;
    pend_tok.offset = out16(ts_off);
    pend_tok.length = out16(pend_len);
    pend_tok.line = out16(ts_line);
    pend_tok.column = out16(ts_col);
    second_tok.kind = byte_item.req_type ? K_EOF : one_kind;
    second_tok.offset = out16(pos);
    second_tok.length = byte_item.req_type ? 16'd0 : 16'd1;
    second_tok.line = out16(line);
    second_tok.column = out16(col);
    run.two = pend && (byte_item.req_type || single);
    run.t0 = pend ? pend_tok : second_tok;
    run.t1 = second_tok;
    push = accept && (pend || single || byte_item.req_type);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= SCAN_IDLE;
      has_dot <= 1'b0;
      pos <= '0;
      line <= POS_ONE;
      col <= POS_ONE;
      ts_off <= '0;
      ts_line <= POS_ONE;
      ts_col <= POS_ONE;
    end else if (accept) begin
      mode <= mode_next;
      has_dot <= has_dot_next;
      pos <= pos_next;
      line <= line_next;
      col <= col_next;
      ts_off <= ts_off_next;
      ts_line <= ts_line_next;
      ts_col <= ts_col_next;
    end
  end

endmodule

[sv/stt_queue.sv]
// Short queue of token runs between the scanner and the output stage.
// Uses stt_pkg and the assertion macros in source_text_tokenizer_defines.svh.
`timescale 1ns / 1ps
`include "source_text_tokenizer_defines.svh"

module stt_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  stt_pkg::run_t push_data,
  input  logic          pop,
  output stt_pkg::run_t head,
  output logic          empty,
  output logic          full
);
  import stt_pkg::*;

  run_t                 entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  localparam logic [QPTR_BITS-1:0] PTR_LAST = QPTR_BITS'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_BITS-1:0] CNT_FULL = QCNT_BITS'(QUEUE_DEPTH);

  assign empty = (count == '0);
  assign full = (count == CNT_FULL);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `STT_ASSERT_NEVER(a_no_push_full, push && full, "Run written into a full queue.")
  `STT_ASSERT_NEVER(a_no_pop_empty, pop && empty, "Run taken from an empty queue.")
  `STT_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + 1'b1, "Queue count lost a write.")
  `STT_ASSERT_NEXT(a_count_down, pop && !push, count == $past(count) - 1'b1, "Queue count lost a read.")

endmodule

[sv/stt_back.sv]
// Output stage: splits each queued run into single tokens and holds them
// in the output register until the consumer takes them. Uses stt_pkg.
`timescale 1ns / 1ps

module stt_back (
  input  logic               clk,
  input  logic               rst,
  input  stt_pkg::run_t      head,
  input  logic               empty,
  input  logic               token_stall,
  output logic               pop,
  output logic               token_valid,
  output stt_pkg::out_item_t token_item
);
  import stt_pkg::*;

  logic   phase;
  logic   load;
  logic   last;
  token_t sel;

  always_comb begin
    load = !token_valid || !token_stall;
    last = phase || !head.two;
    sel = phase ? head.t1 : head.t0;
    pop = load && !empty && last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid <= 1'b0;
      phase <= 1'b0;
    end else if (load) begin
      token_valid <= !empty;
      if (!empty) begin
        phase <= !phase && head.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      token_item.token_kind <= sel.kind;
      token_item.start_offset <= sel.offset;
      token_item.token_length <= sel.length;
      token_item.line_number <= sel.line;
      token_item.column_number <= sel.column;
      token_item.last_of_run <= last;
    end
  end

endmodule

[sv/source_text_tokenizer.sv]
// Streaming tokenizer: takes one source byte or end marker per request and
// returns token descriptors. A token passes the run queue, then the output register.
// One request per cycle is taken while the queue has room; a request that ends two
// tokens emits both in turn; a four-run queue between scanner and output absorbs it.
// Synchronous active-high reset clears the scanner, the queue and the output valid.
`timescale 1ns / 1ps

module source_text_tokenizer (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  stt_pkg::in_item_t  byte_item,
  output logic               token_valid,
  input  logic               token_stall,
  output stt_pkg::out_item_t token_item
);
  import stt_pkg::*;

  logic push;
  logic pop;
  logic empty;
  logic full;
  run_t run;
  run_t head;

  stt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_item  (byte_item),
    .queue_full (full),
    .byte_stall (byte_stall),
    .push       (push),
    .run        (run)
  );

  stt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (run),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  stt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .empty       (empty),
    .token_stall (token_stall),
    .pop         (pop),
    .token_valid (token_valid),
    .token_item  (token_item)
  );

endmodule

[bench/testbench.sv]
// Self-checking testbench for source_text_tokenizer: directed and random source text
// under three idle profiles, each token checked against an in-bench scanner model.
// Depends on stt_pkg and the source_text_tokenizer RTL.
`timescale 1ns / 1ps

module testbench;
  import stt_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_PER_PHASE = 590;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      byte_valid = 1'b0;
  logic      byte_stall;
  in_item_t  byte_item = '0;
  logic      token_valid;
  logic      token_stall = 1'b0;
  out_item_t token_item;

  source_text_tokenizer u_top (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .token_valid(token_valid),
    .token_stall(token_stall),
    .token_item (token_item)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  in_item_t  request_queue[$];
  out_item_t expected_tokens[$];
  out_item_t step_tok [2];
  int        step_n;

  int   pushed_count = 0;
  int   requests_done = 0;
  int   tokens_seen = 0;
  int   errors = 0;
  int   cycles = 0;
  int   phase;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic req_taken = 1'b0;

  string op_list [20] = '{"&=", "=>", "=", "<-", "<", "->", "-", "+", "*", "/",
                          "%", "(", ")", "{", "}", ";", ",", ":", "&", "."};

  scan_mode_t mode_q;
  logic       dot_q;
  pos_t       pos_q, line_q, col_q, st_off_q, st_line_q, st_col_q;

  function automatic pos_t bump(pos_t v);
    return (&v) ? v : pos_t'(v + 1'b1);
  endfunction

  function automatic logic digit_ch(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic letter_ch(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic blank_ch(logic [7:0] b);
    return b == " " || (b >= 8'd9 && b <= 8'd13);
  endfunction

  task automatic reset_scan();
    mode_q = SCAN_IDLE;
    dot_q = 1'b0;
    pos_q = '0;
    line_q = POS_ONE;
    col_q = POS_ONE;
    st_off_q = '0;
    st_line_q = POS_ONE;
    st_col_q = POS_ONE;
  endtask

  task automatic add_tok(logic [4:0] kind, pos_t off, pos_t len, pos_t ln, pos_t cl);
    if (step_n < 2) begin
      step_tok[step_n] = '{token_kind: kind, start_offset: off, token_length: len,
                           line_number: ln, column_number: cl, last_of_run: 1'b0};
      step_n++;
    end
  endtask

  task automatic advance(logic [7:0] b);
    pos_q = bump(pos_q);
    if (b == CH_NL) begin
      line_q = bump(line_q);
      col_q = POS_ONE;
    end else begin
      col_q = bump(col_q);
    end
  endtask

  task automatic mark();
    st_off_q = pos_q;
    st_line_q = line_q;
    st_col_q = col_q;
  endtask

  task automatic pend(logic [4:0] kind);
    add_tok(kind, st_off_q, (pos_q >= st_off_q) ? pos_t'(pos_q - st_off_q) : '0,
            st_line_q, st_col_q);
  endtask

  task automatic single(logic [4:0] kind, logic [7:0] b);
    add_tok(kind, pos_q, POS_ONE, line_q, col_q);
    advance(b);
  endtask

  task automatic start_lexeme(logic [7:0] b);
    mode_q = SCAN_IDLE;
    if (blank_ch(b)) begin
      advance(b);
    end else begin
      mark();
      if (letter_ch(b) || b == CH_UNDER) begin
        mode_q = SCAN_IDENT;
        advance(b);
      end else if (digit_ch(b)) begin
        mode_q = SCAN_NUMBER;
        dot_q = 1'b0;
        advance(b);
      end else begin
        case (b)
          CH_DOT: begin mode_q = SCAN_DOT; advance(b); end
          CH_QUOTE: begin
            advance(b);
            mark();
            mode_q = SCAN_STRING;
          end
          CH_SLASH: begin mode_q = SCAN_SLASH; advance(b); end
          CH_AMP: begin mode_q = SCAN_AMP; advance(b); end
          CH_EQ: begin mode_q = SCAN_EQ; advance(b); end
          CH_LT: begin mode_q = SCAN_LT; advance(b); end
          CH_MINUS: begin mode_q = SCAN_MINUS; advance(b); end
          "+": single(K_PLUS, b);
          "*": single(K_MULT, b);
          "%": single(K_MOD, b);
          "(": single(K_LPAREN, b);
          ")": single(K_RPAREN, b);
          "{": single(K_LBRACE, b);
          "}": single(K_RBRACE, b);
          ";": single(K_SEMI, b);
          ",": single(K_COMMA, b);
          ":": single(K_COLON, b);
          default: single(K_UNKNOWN, b);
        endcase
      end
    end
  endtask

  task automatic pair(logic [7:0] b, logic [7:0] second, logic [4:0] kpair,
                      logic [4:0] kone);
    if (b == second) begin
      advance(b);
      pend(kpair);
      mode_q = SCAN_IDLE;
    end else begin
      pend(kone);
      start_lexeme(b);
    end
  endtask

  task automatic flush_pending();
    case (mode_q)
      SCAN_IDENT: pend(K_IDENT);
      SCAN_NUMBER: pend(dot_q ? K_FLOAT : K_INT);
      SCAN_STRING: pend(K_STRING);
      SCAN_SLASH: pend(K_DIV);
      SCAN_DOT, SCAN_AMP: pend(K_UNKNOWN);
      SCAN_EQ: pend(K_ASSIGN);
      SCAN_LT: pend(K_LT);
      SCAN_MINUS: pend(K_MINUS);
      default: ;
    endcase
  endtask

  task automatic predict_request(in_item_t it);
    logic [7:0] b;
    b = it.char_byte;
    step_n = 0;
    if (it.req_type) begin
      flush_pending();
      add_tok(K_EOF, pos_q, '0, line_q, col_q);
      reset_scan();
    end else begin
      case (mode_q)
        SCAN_IDENT:
          if (letter_ch(b) || digit_ch(b) || b == CH_UNDER) advance(b);
          else begin pend(K_IDENT); start_lexeme(b); end
        SCAN_NUMBER:
          if (digit_ch(b)) advance(b);
          else if (b == CH_DOT && !dot_q) begin dot_q = 1'b1; advance(b); end
          else begin pend(dot_q ? K_FLOAT : K_INT); start_lexeme(b); end
        SCAN_STRING:
          if (b == CH_QUOTE) begin
            pend(K_STRING);
            advance(b);
            mode_q = SCAN_IDLE;
          end else advance(b);
        SCAN_LINECMT:
          if (b == CH_NL) start_lexeme(b);
          else advance(b);
        SCAN_BLOCK: begin
          if (b == CH_BANG) mode_q = SCAN_BLOCKBANG;
          advance(b);
        end
        SCAN_BLOCKBANG: begin
          if (b == CH_SLASH) mode_q = SCAN_IDLE;
          else if (b != CH_BANG) mode_q = SCAN_BLOCK;
          advance(b);
        end
        SCAN_SLASH:
          if (b == CH_BANG) begin mode_q = SCAN_BLOCK; advance(b); end
          else if (b == CH_STAR) begin mode_q = SCAN_LINECMT; advance(b); end
          else begin pend(K_DIV); start_lexeme(b); end
        SCAN_DOT:
          if (digit_ch(b)) begin
            mode_q = SCAN_NUMBER;
            dot_q = 1'b1;
            advance(b);
          end else begin pend(K_UNKNOWN); start_lexeme(b); end
        SCAN_AMP: pair(b, CH_EQ, K_AND_EQ, K_UNKNOWN);
        SCAN_EQ: pair(b, CH_GT, K_FAT_ARROW, K_ASSIGN);
        SCAN_LT: pair(b, CH_MINUS, K_MOVE, K_LT);
        SCAN_MINUS: pair(b, CH_GT, K_ARROW, K_MINUS);
        default: start_lexeme(b);
      endcase
    end
    if (step_n > 0) step_tok[step_n-1].last_of_run = 1'b1;
    for (int k = 0; k < step_n; k++) expected_tokens.insert(expected_tokens.size(), step_tok[k]);
  endtask

  function automatic string tok_text(out_item_t t);
    return $sformatf("kind %0d off %0d len %0d line %0d col %0d last %0d", t.token_kind,
                     t.start_offset, t.token_length, t.line_number, t.column_number,
                     t.last_of_run);
  endfunction

  task automatic push_byte(logic [7:0] b);
    in_item_t it;
    it.req_type = 1'b0;
    it.char_byte = b;
    request_queue.insert(request_queue.size(), it);
    pushed_count++;
  endtask

  task automatic push_end();
    in_item_t it;
    it.req_type = 1'b1;
    it.char_byte = 8'($urandom_range(0, 255));
    request_queue.insert(request_queue.size(), it);
    pushed_count++;
  endtask

  task automatic push_text(string s);
    for (int k = 0; k < s.len(); k++) push_byte(s[k]);
  endtask

  function automatic logic [7:0] rand_word_ch(int top);
    int r;
    r = $urandom_range(0, top);
    if (r < 26) return 8'(r) + "a";
    if (r < 52) return 8'(r - 26) + "A";
    if (r == 52) return CH_UNDER;
    return 8'(r - 53) + "0";
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'($urandom_range(0, 9)) + "0";
  endfunction

  function automatic logic [7:0] rand_blank();
    int r;
    r = $urandom_range(0, 5);
    return (r == 0) ? " " : 8'(8 + r);
  endfunction

  task automatic push_lexeme();
    logic [7:0] b;
    case ($urandom_range(0, 15))
      0, 1, 2: begin
        push_byte(rand_word_ch(52));
        repeat ($urandom_range(0, 7)) push_byte(rand_word_ch(62));
      end
      3, 4: begin
        if ($urandom_range(0, 3) == 0) push_byte(CH_DOT);
        repeat ($urandom_range(1, 4)) push_byte(rand_digit());
        if ($urandom_range(0, 1) == 1) push_byte(CH_DOT);
        repeat ($urandom_range(0, 3)) push_byte(rand_digit());
      end
      5: begin
        push_byte(CH_QUOTE);
        repeat ($urandom_range(0, 6)) begin
          b = 8'($urandom_range(0, 255));
          push_byte((b == CH_QUOTE) ? CH_NL : b);
        end
        if ($urandom_range(0, 7) != 0) push_byte(CH_QUOTE);
      end
      6, 7, 8: push_text(op_list[$urandom_range(0, 19)]);
      9: begin
        push_text("/*");
        repeat ($urandom_range(0, 6)) begin
          b = 8'($urandom_range(0, 255));
          push_byte((b == CH_NL) ? 8'(" ") : b);
        end
        push_byte(CH_NL);
      end
      10: begin
        push_text("/!");
        repeat ($urandom_range(0, 6)) begin
          case ($urandom_range(0, 3))
            0: push_byte(CH_BANG);
            1: push_byte(CH_SLASH);
            default: push_byte(8'($urandom_range(0, 255)));
          endcase
        end
        push_text("!/");
      end
      11, 12: repeat ($urandom_range(1, 3)) push_byte(rand_blank());
      13: repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
      14: push_end();
      default: push_byte(8'($urandom_range(0, 255)));
    endcase
    if ($urandom_range(0, 1) == 1) push_byte(rand_blank());
  endtask

  always @(negedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!byte_valid || req_taken) begin
      if (request_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        byte_item <= request_queue.pop_front();
        byte_valid <= 1'b1;
      end else begin
        byte_valid <= 1'b0;
      end
    end
    token_stall <= !rst && ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin : token_check
    out_item_t want;
    if (rst) begin
      reset_scan();
      req_taken <= 1'b0;
    end else begin
      req_taken <= byte_valid && !byte_stall;
      if (byte_valid && !byte_stall) begin
        predict_request(byte_item);
        requests_done++;
      end
      if (token_valid && !token_stall) begin
        tokens_seen++;
        if (expected_tokens.size() == 0) begin
          errors++;
          $display("%0t: unexpected token, expected none, actual %s", $time,
                   tok_text(token_item));
        end else begin
          want = expected_tokens.pop_front();
          if (token_item !== want) begin
            errors++;
            $display("%0t: token mismatch, expected %s, actual %s", $time,
                     tok_text(want), tok_text(token_item));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int base;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 64 : 0;
      recv_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 29 : 0;
      if (phase == 0) begin
        push_text("&=&;=>=;<-<;->-;+*%(){},:");
        push_end();
        push_text("42_a9 1.2.3 .5.;/*c\n/!!x!/");
        push_byte(8'h00);
        push_byte(8'hFF);
        push_text("/ \"a\n");
        push_end();
        push_text("\"ok\"=");
        push_end();
        push_end();
        push_text("/!x");
        push_end();
      end
      base = pushed_count;
      while (pushed_count - base < RANDOM_PER_PHASE) push_lexeme();
      push_end();
      while (requests_done != pushed_count || expected_tokens.size() != 0) @(posedge clk);
    end
    repeat (10) @(posedge clk);
    $display("Summary: %0d requests accepted, %0d tokens checked, %0d mismatches.",
             requests_done, tokens_seen, errors);
    $display("Exercised every operator, both comment styles, strings and end-of-input flushes.");
    if (errors == 0 && expected_tokens.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
